FILE: hdl/blpd_pkg.sv
package blpd_pkg;

  // Table size and brightness width.
  localparam int TABLE_POINTS    = 5;
  localparam int BRIGHTNESS_BITS = 8;
  localparam int TUNE_BITS       = 5;
  localparam int POINT_BITS      = BRIGHTNESS_BITS + TUNE_BITS;
  localparam int IDX_BITS        = $clog2(TABLE_POINTS);

  // Dividend of the interpolation: brightness span times tune difference.
  localparam int NUM_BITS = BRIGHTNESS_BITS + TUNE_BITS;
  localparam int CNT_BITS = $clog2(NUM_BITS);

  // Level that turns on high-brightness mode.
  localparam int AUTO_BITS = 4;
  localparam logic [AUTO_BITS-1:0] HBM_THRESHOLD = AUTO_BITS'(6);

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OUTDOOR = CFG_IDX_BITS'(TABLE_POINTS);
  localparam logic [CFG_IDX_BITS-1:0] CFG_AUTO    = CFG_IDX_BITS'(TABLE_POINTS + 1);
  localparam int CFG_DATA_BITS = POINT_BITS;

  // Command queue between classifier and execution unit.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef logic [POINT_BITS-1:0] point_t;
  typedef point_t [TABLE_POINTS-1:0] table_t;

  typedef struct packed {
    logic [BRIGHTNESS_BITS-1:0] brightness;
    logic                       blanked;
  } in_t;

  typedef struct packed {
    logic                 status;
    logic [TUNE_BITS-1:0] level;
    logic                 level_changed;
    logic                 power_off;
    logic                 power_on;
    logic [TUNE_BITS-1:0] pulse_count;
  } out_t;

  typedef enum logic [1:0] {
    CMD_ERROR,
    CMD_DIRECT,
    CMD_INTERP
  } cmd_kind_t;

  // One classified request. For CMD_INTERP, tune holds the upper point's level.
  typedef struct packed {
    cmd_kind_t                  kind;
    logic [TUNE_BITS-1:0]       tune;
    logic [BRIGHTNESS_BITS-1:0] span;
    logic [BRIGHTNESS_BITS-1:0] den;
    logic                       tdiff_neg;
    logic [TUNE_BITS-1:0]       tdiff_mag;
  } cmd_t;

  // Brightness and tune fields of a table point.
  function automatic logic [BRIGHTNESS_BITS-1:0] pt_brt(input point_t p);
    pt_brt = p[BRIGHTNESS_BITS-1:0];
  endfunction

  function automatic logic [TUNE_BITS-1:0] pt_tune(input point_t p);
    pt_tune = p[POINT_BITS-1:BRIGHTNESS_BITS];
  endfunction

  // Reset contents of a table point.
  function automatic point_t reset_point(input int k);
    logic [BRIGHTNESS_BITS-1:0] b;
    logic [TUNE_BITS-1:0]       t;
    b = '1;
    t = '1;
    case (k)
      0: begin
        b = '0;
        t = TUNE_BITS'(0);
      end
      1: begin
        b = BRIGHTNESS_BITS'(1);
        t = TUNE_BITS'(1);
      end
      2: begin
        b = BRIGHTNESS_BITS'(20);
        t = TUNE_BITS'(2);
      end
      3: begin
        b = BRIGHTNESS_BITS'(128);
        t = TUNE_BITS'(16);
      end
      default: begin
        b = '1;
        t = '1;
      end
    endcase
    reset_point = {t, b};
  endfunction

endpackage

FILE: hdl/backlight_level_interp_pulse_dimming_unit.sv
// Backlight level mapper with pulse dimming.
// Input channel (in_valid/in_ready/in_data): one brightness request per item,
// with a blank flag that forces the request to zero. Each request gives one
// result on the output channel (out_valid/out_ready/out_data): status, level,
// change flag, power-off, power-on and down-pulse count.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): indexes 0 to
// 4 write the table points, 5 the outdoor tune level, 6 the automatic level.
// It is always ready; other indexes are ignored. Write it only while idle.
// A request is classified in the cycle it is accepted and queued in a
// two-entry command queue. Error and direct results pass from the queue to
// the output register, and such requests can follow one per cycle while the
// receiver takes them. For an interpolated result, the product is registered,
// the restoring divider gives one quotient bit per cycle, and a final state
// writes the result. The divider takes one interpolated request at a time;
// later commands wait in the queue. While the receiver stalls, the result is
// held in the output register, the queue fills, and then in_ready drops.
// Reset restores the table defaults and sets the kept level to zero (off).
module backlight_level_interp_pulse_dimming_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  blpd_pkg::in_t                           in_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output blpd_pkg::out_t                          out_data,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [blpd_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [blpd_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  blpd_pkg::table_t                      points_r, points_nxt;
  logic [blpd_pkg::TUNE_BITS-1:0]        outdoor_r, outdoor_nxt;
  logic [blpd_pkg::AUTO_BITS-1:0]        auto_r, auto_nxt;
  logic                                  q_full;
  logic                                  q_push;
  blpd_pkg::cmd_t                        q_wdata;
  logic                                  q_pop;
  logic                                  q_valid;
  blpd_pkg::cmd_t                        q_rdata;

  assign cfg_ready = 1'b1;

  // Configuration register decode.
  always_comb begin
    points_nxt  = points_r;
    outdoor_nxt = outdoor_r;
    auto_nxt    = auto_r;
    if (cfg_valid) begin
      if (cfg_index < blpd_pkg::CFG_OUTDOOR) begin
        points_nxt[cfg_index[blpd_pkg::IDX_BITS-1:0]] = cfg_data[blpd_pkg::POINT_BITS-1:0];
      end else if (cfg_index == blpd_pkg::CFG_OUTDOOR) begin
        outdoor_nxt = cfg_data[blpd_pkg::TUNE_BITS-1:0];
      end else if (cfg_index == blpd_pkg::CFG_AUTO) begin
        auto_nxt = cfg_data[blpd_pkg::AUTO_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < blpd_pkg::TABLE_POINTS; i++) begin
        points_r[i] <= blpd_pkg::reset_point(i);
      end
      outdoor_r <= '1;
      auto_r    <= '0;
    end else begin
      points_r  <= points_nxt;
      outdoor_r <= outdoor_nxt;
      auto_r    <= auto_nxt;
    end
  end

  // Request classifier.
  blpd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .points        (points_r),
    .auto_level    (auto_r),
    .outdoor_level (outdoor_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  // Command queue.
  blpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_rdata)
  );

  // Divider, level tracking and output register.
  blpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/blpd_front.sv
module blpd_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  blpd_pkg::in_t                        in_data,
  input  blpd_pkg::table_t                     points,
  input  logic [blpd_pkg::AUTO_BITS-1:0]       auto_level,
  input  logic [blpd_pkg::TUNE_BITS-1:0]       outdoor_level,
  input  logic                                 q_full,
  output logic                                 q_push,
  output blpd_pkg::cmd_t                       q_data
);

  logic [blpd_pkg::BRIGHTNESS_BITS-1:0] b;
  logic [blpd_pkg::BRIGHTNESS_BITS-1:0] maxb;
  logic [blpd_pkg::IDX_BITS-1:0]        k;
  logic [blpd_pkg::IDX_BITS-1:0]        kp;
  logic [blpd_pkg::BRIGHTNESS_BITS-1:0] brt_k;
  logic [blpd_pkg::BRIGHTNESS_BITS-1:0] brt_p;
  logic [blpd_pkg::TUNE_BITS-1:0]       tune_k;
  logic [blpd_pkg::TUNE_BITS-1:0]       tune_p;

  // The classifier is combinational; the queue gives the registered boundary.
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Effective request and table maximum.
  assign b    = in_data.blanked ? '0 : in_data.brightness;
  assign maxb = blpd_pkg::pt_brt(points[blpd_pkg::TABLE_POINTS-1]);

  // First point at or above the request; the last point when none is.
  always_comb begin
    k = blpd_pkg::IDX_BITS'(blpd_pkg::TABLE_POINTS - 1);
    for (int i = blpd_pkg::TABLE_POINTS - 2; i >= 0; i--) begin
      if (b <= blpd_pkg::pt_brt(points[i])) begin
        k = blpd_pkg::IDX_BITS'(i);
      end
    end
  end

  assign kp     = k - blpd_pkg::IDX_BITS'(1);
  assign brt_k  = blpd_pkg::pt_brt(points[k]);
  assign brt_p  = blpd_pkg::pt_brt(points[kp]);
  assign tune_k = blpd_pkg::pt_tune(points[k]);
  assign tune_p = blpd_pkg::pt_tune(points[k == '0 ? k : kp]);

  // Build the command for the execution unit.
  always_comb begin
    q_data           = '0;
    q_data.kind      = blpd_pkg::CMD_DIRECT;
    q_data.tune      = tune_k;
    q_data.span      = brt_k - b;
    q_data.den       = brt_k - brt_p;
    q_data.tdiff_neg = tune_k < tune_p;
    q_data.tdiff_mag = (tune_k < tune_p) ? (tune_p - tune_k) : (tune_k - tune_p);
    if (b > maxb) begin
      q_data.kind = blpd_pkg::CMD_ERROR;
    end else if (auto_level >= blpd_pkg::HBM_THRESHOLD && b == maxb) begin
      q_data.tune = outdoor_level;
    end else if (k > blpd_pkg::IDX_BITS'(1)) begin
      q_data.kind = blpd_pkg::CMD_INTERP;
    end
  end

`ifndef SYNTH
  // An interpolated command always has a lower neighbor with smaller brightness.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_data.kind == blpd_pkg::CMD_INTERP |-> q_data.den != '0)
    else $error("interpolation with zero brightness span");
  // An error is only raised for a request above the table maximum.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_data.kind == blpd_pkg::CMD_ERROR |-> !in_data.blanked)
    else $error("blanked request classified as error");
  // The span never exceeds the distance between the two points.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_data.kind == blpd_pkg::CMD_INTERP |-> q_data.span < q_data.den)
    else $error("request outside its interpolation interval");
`endif

endmodule

FILE: hdl/blpd_queue.sv
module blpd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  blpd_pkg::cmd_t      push_data,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output blpd_pkg::cmd_t      data
);

  blpd_pkg::cmd_t                  mem_r [blpd_pkg::QUEUE_DEPTH];
  logic [blpd_pkg::QPTR_BITS-1:0]  wptr_r, wptr_nxt;
  logic [blpd_pkg::QPTR_BITS-1:0]  rptr_r, rptr_nxt;
  logic [blpd_pkg::QPTR_BITS:0]    count_r, count_nxt;

  assign full  = count_r == (blpd_pkg::QPTR_BITS + 1)'(blpd_pkg::QUEUE_DEPTH);
  assign valid = count_r != '0;
  assign data  = mem_r[rptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wptr_nxt  = push ? wptr_r + blpd_pkg::QPTR_BITS'(1) : wptr_r;
    rptr_nxt  = pop ? rptr_r + blpd_pkg::QPTR_BITS'(1) : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (blpd_pkg::QPTR_BITS + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (blpd_pkg::QPTR_BITS + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

`ifndef SYNTH
  // The classifier never pushes into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  // The executor never pops an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> valid)
    else $error("pop from empty queue");
  // The fill count never exceeds the depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (blpd_pkg::QPTR_BITS + 1)'(blpd_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");
`endif

endmodule

FILE: hdl/blpd_back.sv
module blpd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  blpd_pkg::cmd_t      q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output blpd_pkg::out_t      out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } state_t;

  localparam int NB = blpd_pkg::NUM_BITS;
  localparam int BB = blpd_pkg::BRIGHTNESS_BITS;
  localparam int TB = blpd_pkg::TUNE_BITS;

  state_t                          state_r, state_nxt;
  logic [TB-1:0]                   level_r, level_nxt;
  logic                            out_valid_r, out_valid_nxt;
  blpd_pkg::out_t                  out_data_r, out_data_nxt;
  logic [NB-1:0]                   dvd_r, dvd_nxt;
  logic [BB-1:0]                   rem_r, rem_nxt;
  logic [BB-1:0]                   den_r, den_nxt;
  logic [blpd_pkg::CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                            neg_r, neg_nxt;
  logic [TB-1:0]                   tune_k_r, tune_k_nxt;

  logic                            out_free;
  logic [BB:0]                     rem_sh;
  logic                            rem_ge;
  logic signed [NB+1:0]            t_wide;
  logic [TB-1:0]                   t_interp;
  logic [TB-1:0]                   tune_sel;
  logic                            is_err;
  blpd_pkg::out_t                  res;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Pop a command when idle; direct and error commands also need the output slot.
  assign q_pop = (state_r == S_IDLE) && q_valid &&
                 (q_data.kind == blpd_pkg::CMD_INTERP || out_free);

  // One restoring division step per cycle.
  assign rem_sh = {rem_r, dvd_r[NB-1]};
  assign rem_ge = rem_sh >= {1'b0, den_r};

  // Interpolated level, clamped to the tune range.
  always_comb begin
    if (neg_r) begin
      t_wide = $signed({2'b00, {(NB - TB){1'b0}}, tune_k_r}) + $signed({2'b00, dvd_r});
    end else begin
      t_wide = $signed({2'b00, {(NB - TB){1'b0}}, tune_k_r}) - $signed({2'b00, dvd_r});
    end
    if (t_wide < 0) begin
      t_interp = '0;
    end else if (t_wide > (NB + 2)'(2 ** TB - 1)) begin
      t_interp = '1;
    end else begin
      t_interp = t_wide[TB-1:0];
    end
  end

  // Result of the command that completes this cycle.
  always_comb begin
    is_err   = (state_r == S_IDLE) && q_data.kind == blpd_pkg::CMD_ERROR;
    tune_sel = (state_r == S_FIN) ? t_interp : q_data.tune;
    res      = '0;
    if (is_err) begin
      res.status = 1'b1;
      res.level  = level_r;
    end else begin
      res.level = tune_sel;
      if (tune_sel != level_r) begin
        res.level_changed = 1'b1;
        if (tune_sel == '0) begin
          res.power_off = 1'b1;
        end else begin
          res.power_on    = level_r == '0;
          res.pulse_count = level_r - tune_sel;
        end
      end
    end
  end

  // Sequencer: on pop, write a direct or error result or load the divider; iterate it, then write the result.
  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    tune_k_nxt    = tune_k_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          if (q_data.kind == blpd_pkg::CMD_INTERP) begin
            dvd_nxt    = NB'(q_data.span * q_data.tdiff_mag);
            rem_nxt    = '0;
            den_nxt    = q_data.den;
            cnt_nxt    = '0;
            neg_nxt    = q_data.tdiff_neg;
            tune_k_nxt = q_data.tune;
            state_nxt  = S_DIV;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = res;
            level_nxt     = res.level;
          end
        end
      end
      S_DIV: begin
        rem_nxt = rem_ge ? BB'(rem_sh - {1'b0, den_r}) : rem_sh[BB-1:0];
        dvd_nxt = {dvd_r[NB-2:0], rem_ge};
        cnt_nxt = cnt_r + blpd_pkg::CNT_BITS'(1);
        if (cnt_r == blpd_pkg::CNT_BITS'(NB - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res;
          level_nxt     = res.level;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    tune_k_r   <= tune_k_nxt;
  end

`ifndef SYNTH
  // A held result always reports the level that is now kept.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.level == level_r)
    else $error("result level differs from kept level");
  // The divider never runs with a zero divisor.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> den_r != '0)
    else $error("division by zero");
  // Power-off and power-on are never reported together.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.power_off && out_data_r.power_on))
    else $error("power off and on in one result");
  // The kept level only moves when a result is written.
  assert property (@(posedge clk) disable iff (!rst_n)
    level_r != $past(level_r) |-> out_valid_r)
    else $error("level changed without a result");
`endif

endmodule

FILE: verif/backlight_level_interp_pulse_dimming_unit_tb.sv
`timescale 1ns / 1ps

module backlight_level_interp_pulse_dimming_unit_tb;
  import blpd_pkg::*;

  // Register indexes of the first table point and of the first unused slot.
  localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_BASE   = '0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_UNUSED = CFG_AUTO + 1'b1;

  localparam int IDLE_PERCENT  = 32;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 24;
  localparam int RANDOM_PHASES = 16;
  localparam int PHASE_ITEMS   = 110;
  localparam int BURST_ITEMS   = 60;
  localparam int REPORT_LIMIT  = 200;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  in_t                      in_data   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_t                     out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

  // Shadow copy of the configuration and of the kept level.
  point_t               table_copy [TABLE_POINTS];
  logic [TUNE_BITS-1:0] outdoor_copy;
  logic [AUTO_BITS-1:0] auto_copy;
  logic [TUNE_BITS-1:0] kept_level;

  out_t expected_levels[$];
  int   mismatch_count = 0;
  int   result_count   = 0;

  // Idle control and the long receiver hold-off.
  logic idle_on      = 1'b1;
  int   hold_token   = 0;
  int   hold_served  = 0;
  int   hold_left    = 0;

  backlight_level_interp_pulse_dimming_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Fields of a point in the shadow table.
  function automatic int point_brightness(input int k);
    return int'(table_copy[k][BRIGHTNESS_BITS-1:0]);
  endfunction

  function automatic int point_tune(input int k);
    return int'(table_copy[k][POINT_BITS-1:BRIGHTNESS_BITS]);
  endfunction

  // Maps one request to its expected result and updates the kept level.
  function automatic out_t predict_level(input in_t req);
    out_t                 res;
    int                   b;
    int                   k;
    int                   num;
    int                   den;
    int                   t;
    logic [TUNE_BITS-1:0] tune;
    res = '0;
    res.level = kept_level;
    b = req.blanked ? 0 : int'(req.brightness);
    if (b > point_brightness(TABLE_POINTS - 1)) begin
      res.status = 1'b1;
      return res;
    end
    if (auto_copy >= HBM_THRESHOLD && b == point_brightness(TABLE_POINTS - 1)) begin
      tune = outdoor_copy;
    end else begin
      // The first point at or above the request; the last point if none before it.
      k = 0;
      while (k < TABLE_POINTS - 1 && b > point_brightness(k)) k++;
      if (k <= 1) begin
        tune = TUNE_BITS'(point_tune(k));
      end else begin
        num = (point_brightness(k) - b) * (point_tune(k) - point_tune(k - 1));
        den = point_brightness(k) - point_brightness(k - 1);
        if (den <= 0) den = 1;
        t = point_tune(k) - num / den;
        if (t < 0) t = 0;
        if (t > 31) t = 31;
        tune = TUNE_BITS'(t);
      end
    end
    res.level = tune;
    if (tune != kept_level) begin
      res.level_changed = 1'b1;
      if (tune == '0) begin
        res.power_off = 1'b1;
      end else begin
        res.power_on    = (kept_level == '0);
        res.pulse_count = kept_level - tune;
      end
      kept_level = tune;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    if (mismatch_count < REPORT_LIMIT) begin
      $display("[%0t] result %0d: %s expected %0d, got %0d", $realtime, result_count,
               what, want, got);
    end
    mismatch_count++;
  endtask

  // Compares one delivered result with the oldest pending expectation.
  task automatic check_result(input out_t got);
    out_t want;
    if (expected_levels.size() == 0) begin
      report_mismatch("unrequested result, level", -1, int'(got.level));
    end else begin
      want = expected_levels.pop_front();
      if (got.status != want.status)
        report_mismatch("status", want.status, got.status);
      if (got.level != want.level)
        report_mismatch("level", want.level, got.level);
      if (got.level_changed != want.level_changed)
        report_mismatch("level_changed", want.level_changed, got.level_changed);
      if (got.power_off != want.power_off)
        report_mismatch("power_off", want.power_off, got.power_off);
      if (got.power_on != want.power_on)
        report_mismatch("power_on", want.power_on, got.power_on);
      if (got.pulse_count != want.pulse_count)
        report_mismatch("pulse_count", want.pulse_count, got.pulse_count);
    end
    result_count++;
  endtask

  // Result side: checks each delivered result.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
  end

  // Receiver ready: random idling, or a long hold-off counted in cycles.
  always @(posedge clk) begin
    if (hold_token != hold_served) begin
      hold_served <= hold_token;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= (hold_left == 1);
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Offers one request, waits for it to be taken and records its expected result.
  task automatic send_request(input in_t req);
    if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PERCENT);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_levels.push_back(predict_level(req));
  endtask

  task automatic send_value(input int brightness, input bit blanked);
    in_t req;
    req.brightness = BRIGHTNESS_BITS'(brightness);
    req.blanked    = blanked;
    send_request(req);
  endtask

  // Stops offering and waits until every pending result has been delivered.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One configuration write; the shadow copy follows at the handshake.
  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < TABLE_POINTS) begin
      table_copy[idx[IDX_BITS-1:0]] = value;
    end else if (idx == CFG_OUTDOOR) begin
      outdoor_copy = value[TUNE_BITS-1:0];
    end else if (idx == CFG_AUTO) begin
      auto_copy = value[AUTO_BITS-1:0];
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_point(input int k, input int brightness, input int tune);
    write_register(CFG_POINT_BASE + CFG_IDX_BITS'(k),
                   {TUNE_BITS'(tune), BRIGHTNESS_BITS'(brightness)});
  endtask

  task automatic write_default_table();
    write_point(0, 0, 0);
    write_point(1, 1, 1);
    write_point(2, 20, 2);
    write_point(3, 128, 16);
    write_point(4, 255, 31);
  endtask

  // Random table: mostly ascending brightness, sometimes fully scrambled.
  task automatic write_random_table(input bit sorted);
    int brt;
    int tune;
    brt  = $urandom_range(20);
    tune = ($urandom_range(1) == 0) ? 0 : $urandom_range(31);
    for (int k = 0; k < TABLE_POINTS; k++) begin
      if (!sorted) begin
        brt  = $urandom_range(255);
        tune = $urandom_range(31);
      end else if (k > 0) begin
        brt = brt + $urandom_range(90);
        if (brt > 255 || (k == TABLE_POINTS - 1 && $urandom_range(1) == 0)) brt = 255;
        tune = ($urandom_range(3) == 0) ? $urandom_range(31) : tune + $urandom_range(12);
        if (tune > 31) tune = 31;
      end
      write_point(k, brt, tune);
    end
    write_register(CFG_OUTDOOR, CFG_DATA_BITS'($urandom_range(31)));
    write_register(CFG_AUTO, CFG_DATA_BITS'($urandom_range(1) == 0 ?
                                            $urandom_range(5) : $urandom_range(15, 6)));
  endtask

  // Random request, leaning toward table points, the top point, all ones and zero.
  function automatic in_t random_request();
    in_t req;
    int  pick;
    int  k;
    pick = $urandom_range(99);
    k    = $urandom_range(TABLE_POINTS - 1);
    if (pick < 30) begin
      req.brightness = BRIGHTNESS_BITS'(point_brightness(k) + int'($urandom_range(2)) - 1);
    end else if (pick < 40) begin
      req.brightness = BRIGHTNESS_BITS'(point_brightness(TABLE_POINTS - 1));
    end else if (pick < 45) begin
      req.brightness = '1;
    end else if (pick < 50) begin
      req.brightness = '0;
    end else begin
      req.brightness = BRIGHTNESS_BITS'($urandom_range(255));
    end
    req.blanked = ($urandom_range(7) == 0);
    return req;
  endfunction

  // Reset table: each segment, the points themselves, power on and off.
  task automatic test_default_table();
    send_value(0, 1'b0);
    send_value(1, 1'b0);
    send_value(10, 1'b0);
    send_value(21, 1'b0);
    send_value(100, 1'b0);
    send_value(128, 1'b0);
    send_value(129, 1'b0);
    send_value(255, 1'b0);
    send_value(254, 1'b0);
    send_value(200, 1'b1);
    send_value(20, 1'b0);
    wait_idle();
  endtask

  // Requests above the top point, then all-zero and all-one settings.
  task automatic test_table_limits();
    write_point(4, 100, 20);
    send_value(101, 1'b0);
    send_value(255, 1'b0);
    send_value(100, 1'b0);
    send_value(255, 1'b1);
    wait_idle();
    for (int k = 0; k < TABLE_POINTS; k++) write_point(k, 0, 0);
    write_register(CFG_OUTDOOR, '0);
    write_register(CFG_AUTO, '0);
    send_value(0, 1'b0);
    send_value(1, 1'b0);
    send_value(255, 1'b0);
    wait_idle();
    for (int k = 0; k < TABLE_POINTS; k++) write_register(CFG_POINT_BASE + CFG_IDX_BITS'(k), '1);
    write_register(CFG_OUTDOOR, CFG_DATA_BITS'(31));
    write_register(CFG_AUTO, CFG_DATA_BITS'(15));
    send_value(255, 1'b0);
    send_value(0, 1'b0);
    send_value(128, 1'b0);
    wait_idle();
  endtask

  // High-brightness mode at and just below its threshold; unused indexes ignored.
  task automatic test_high_brightness();
    write_default_table();
    write_register(CFG_OUTDOOR, CFG_DATA_BITS'(5));
    write_register(CFG_AUTO, CFG_DATA_BITS'(HBM_THRESHOLD));
    send_value(255, 1'b0);
    wait_idle();
    write_register(CFG_AUTO, CFG_DATA_BITS'(HBM_THRESHOLD - 1'b1));
    send_value(255, 1'b0);
    wait_idle();
    write_register(CFG_AUTO, CFG_DATA_BITS'(15));
    write_register(CFG_OUTDOOR, '0);
    send_value(255, 1'b0);
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      write_register(CFG_FIRST_UNUSED + CFG_IDX_BITS'($urandom_range(8)),
                     CFG_DATA_BITS'($urandom));
    end
    send_value(128, 1'b0);
    send_value(255, 1'b0);
    wait_idle();
  endtask

  // Scrambled table: the first point at or above still wins; falling tune levels.
  task automatic test_unsorted_table();
    write_point(0, 0, 0);
    write_point(1, 200, 10);
    write_point(2, 50, 31);
    write_point(3, 100, 3);
    write_point(4, 255, 20);
    write_register(CFG_AUTO, '0);
    send_value(150, 1'b0);
    send_value(250, 1'b0);
    send_value(101, 1'b0);
    wait_idle();
    write_point(1, 10, 2);
    write_point(2, 200, 0);
    write_point(3, 30, 25);
    write_point(4, 220, 1);
    send_value(210, 1'b0);
    send_value(31, 1'b0);
    wait_idle();
  endtask

  // Random requests over many random settings, one phase without idling.
  task automatic test_random_phases();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_on <= (p != 5);
      write_random_table(p % 4 != 3);
      for (int i = 0; i < PHASE_ITEMS; i++) send_request(random_request());
      wait_idle();
    end
    idle_on <= 1'b1;
  endtask

  // The receiver holds off while requests keep coming, so the input stalls.
  task automatic test_backpressure();
    write_random_table(1'b1);
    hold_token <= hold_token + 1;
    for (int i = 0; i < BURST_ITEMS; i++) send_request(random_request());
    wait_idle();
  endtask

  initial begin
    table_copy[0] = 13'd0;
    table_copy[1] = 13'd257;
    table_copy[2] = 13'd532;
    table_copy[3] = 13'd4224;
    table_copy[4] = 13'd8191;
    outdoor_copy  = 5'd31;
    auto_copy     = '0;
    kept_level    = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_default_table();
    test_table_limits();
    test_high_brightness();
    test_unsorted_table();
    test_random_phases();
    test_backpressure();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
hdl/blpd_pkg.sv
hdl/blpd_front.sv
hdl/blpd_queue.sv
hdl/blpd_back.sv
hdl/backlight_level_interp_pulse_dimming_unit.sv
verif/backlight_level_interp_pulse_dimming_unit_tb.sv
